// ===== rtl/four_way_transposition_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-way transposition table
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_WAY_TRANSPOSITION_TABLE_MACROS_SVH
`define FOUR_WAY_TRANSPOSITION_TABLE_MACROS_SVH

// same-cycle implication
`define FWTT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fwtt assertion failed");

// next-cycle implication
`define FWTT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fwtt assertion failed");

`endif

// ===== rtl/fwtt_pkg.sv =====
// ----------------------------------------------------------------------------
// fwtt_pkg
// Types and constants of the four-way transposition table.
// ----------------------------------------------------------------------------
package fwtt_pkg;

    localparam int BUCKETS     = 1024;
    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int WAYS        = 4;
    localparam int WAY_BITS    = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 48;
    localparam int APB_AW    = 3;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        OUT_HIT           = 3'd0,
        OUT_MISS          = 3'd1,
        OUT_STORE_FREE    = 3'd2,
        OUT_STORE_STALE   = 3'd3,
        OUT_STORE_SHALLOW = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  epoch;
        logic [7:0]  depth;
        logic [15:0] score;
        logic [15:0] move;
        logic [63:0] key;
        logic        valid;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] bucket_row_t;

endpackage

// ===== rtl/four_way_transposition_table.sv =====
// An accepted request's bucket row is read into a register; in ST_LOOK, once
// the output register is free, the row is written back to the single-port
// bucket memory and the result is registered. One request is taken at a time.
// Reset: synchronous, active low; then a clearing pass over all 1024 rows
// (one bucket row per cycle) runs with s_tready low; APB writes are taken.
// ----------------------------------------------------------------------------
// four_way_transposition_table
// Four-way set-associative position cache with depth and age replacement.
// ----------------------------------------------------------------------------
module four_way_transposition_table
    import fwtt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // position_key, store_score, store_node_kind, store_depth, store_move
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // way, found_score, found_node_kind, found_depth, found_move
    output logic [M_TDATA_W-1:0]  m_tdata,
    // outcome
    output logic [2:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    bucket_row_t mem [BUCKETS];

    state_t                 state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]             epoch_reg;

    bucket_row_t            rd_row_reg;
    opcode_t                op_reg;
    logic [63:0]            key_reg;
    logic [15:0]            score_reg;
    logic [1:0]             kind_reg;
    logic [7:0]             depth_reg;
    logic [15:0]            move_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    outcome_t               m_tuser_reg;

    logic                   accept;
    logic                   wr_en;
    logic [BUCKET_BITS-1:0] wr_addr;
    bucket_row_t            wr_row;
    logic                   load_out;

    logic                   hit, free, stale;
    logic [WAY_BITS-1:0]    hit_way, free_way, stale_way, min_way, sel_way;
    logic [7:0]             min_depth;
    outcome_t               outcome;
    bucket_row_t            new_row;
    way_entry_t             hit_entry;
    logic [M_TDATA_W-1:0]   res_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, epoch_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= 8'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            epoch_reg <= pwdata[7:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (accept) begin
            rd_row_reg <= mem[s_tdata[BUCKET_BITS-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= opcode_t'(s_tuser);
            key_reg   <= s_tdata[63:0];
            score_reg <= s_tdata[79:64];
            kind_reg  <= s_tdata[81:80];
            depth_reg <= s_tdata[89:82];
            move_reg  <= s_tdata[105:90];
        end
    end

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        free      = 1'b0;
        free_way  = '0;
        stale     = 1'b0;
        stale_way = '0;
        min_way   = '0;
        min_depth = rd_row_reg[0].depth;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (rd_row_reg[i].valid && rd_row_reg[i].key == key_reg) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(i);
            end
            if (!rd_row_reg[i].valid || rd_row_reg[i].key == key_reg) begin
                free     = 1'b1;
                free_way = WAY_BITS'(i);
            end
            if (rd_row_reg[i].epoch < epoch_reg) begin
                stale     = 1'b1;
                stale_way = WAY_BITS'(i);
            end
        end
        for (int i = 1; i < WAYS; i++) begin
            if (rd_row_reg[i].depth < min_depth) begin
                min_depth = rd_row_reg[i].depth;
                min_way   = WAY_BITS'(i);
            end
        end

        new_row   = rd_row_reg;
        hit_entry = rd_row_reg[hit_way];
        res_data  = '0;
        sel_way   = '0;
        if (op_reg == OP_LOOKUP) begin
            if (hit) begin
                outcome                = OUT_HIT;
                new_row[hit_way].epoch = epoch_reg;
                res_data = {4'd0, hit_entry.move, hit_entry.depth, hit_entry.kind,
                            hit_entry.score, hit_way};
            end else begin
                outcome = OUT_MISS;
            end
        end else begin
            if (free) begin
                outcome = OUT_STORE_FREE;
                sel_way = free_way;
            end else if (stale) begin
                outcome = OUT_STORE_STALE;
                sel_way = stale_way;
            end else begin
                outcome = OUT_STORE_SHALLOW;
                sel_way = min_way;
            end
            new_row[sel_way] = '{kind: kind_reg, epoch: epoch_reg, depth: depth_reg,
                                 score: score_reg, move: move_reg, key: key_reg,
                                 valid: 1'b1};
            res_data = {{(M_TDATA_W - WAY_BITS){1'b0}}, sel_way};
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        wr_en         = 1'b0;
        wr_addr       = key_reg[BUCKET_BITS-1:0];
        wr_row        = new_row;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_row        = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BUCKET_BITS'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!m_tvalid_reg || m_tready) begin
                    wr_en      = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= outcome;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/fwtt_checker.sv =====
// ----------------------------------------------------------------------------
// fwtt_checker
// Port-level checks of the four-way transposition table, bound to the top.
// ----------------------------------------------------------------------------
`include "four_way_transposition_table_macros.svh"

module fwtt_checker
    import fwtt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [2:0]           m_tuser
);

    `FWTT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `FWTT_ASSERT_NOW(a_outcome_code, aclk, aresetn, m_tvalid, m_tuser <= OUT_STORE_SHALLOW)
    `FWTT_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_tvalid && m_tuser == OUT_MISS, m_tdata == '0)
    `FWTT_ASSERT_NOW(a_store_no_data, aclk, aresetn, m_tvalid && (m_tuser == OUT_STORE_FREE || m_tuser == OUT_STORE_STALE || m_tuser == OUT_STORE_SHALLOW), m_tdata[M_TDATA_W-1:WAY_BITS] == '0)
    `FWTT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind four_way_transposition_table fwtt_checker u_fwtt_checker (.*);

// ===== bench/fwtt_table_checker.sv =====
// ----------------------------------------------------------------------------
// fwtt_table_checker
// Watches the request, result and register channels of the four-way
// transposition table. Keeps its own copy of the buckets and the epoch and
// works out the answer to every accepted request. Each accepted result is
// compared field by field with the oldest answer still awaited.
// ----------------------------------------------------------------------------
module fwtt_table_checker
    import fwtt_pkg::*;
#(
    parameter logic [APB_AW-1:0] EPOCH_ADDR = '0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [2:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int unsigned           mismatch_count,
    output int unsigned           awaited_count
);

    localparam int SLOTS = BUCKETS * WAYS;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  epoch;
        logic [7:0]  depth;
        logic [15:0] score;
        logic [15:0] move;
    } slot_payload_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [1:0]         way;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [7:0]         depth;
        logic [15:0]        move;
    } probe_result_t;

    bit            slot_valid [SLOTS];
    logic [63:0]   slot_key   [SLOTS];
    slot_payload_t slot_pay   [SLOTS];
    logic [7:0]    epoch;

    probe_result_t awaited_results [$];

    function automatic probe_result_t probe_table(
        input opcode_t            op,
        input logic [63:0]        key,
        input logic signed [15:0] score,
        input logic [1:0]         kind,
        input logic [7:0]         depth,
        input logic [15:0]        move
    );
        probe_result_t r;
        int            base;
        int            pick;
        bit            chosen;
        logic [7:0]    best;

        r = '0;
        r.outcome = OUT_MISS;
        base = int'(key[BUCKET_BITS-1:0]) * WAYS;
        chosen = 1'b0;
        pick = 0;
        if (op == OP_LOOKUP) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!chosen && slot_valid[base+w] && slot_key[base+w] == key) begin
                    chosen = 1'b1;
                    slot_pay[base+w].epoch = epoch;
                    r.outcome = OUT_HIT;
                    r.way = w[1:0];
                    r.score = slot_pay[base+w].score;
                    r.kind = slot_pay[base+w].kind;
                    r.depth = slot_pay[base+w].depth;
                    r.move = slot_pay[base+w].move;
                end
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (!chosen && (!slot_valid[base+w] || slot_key[base+w] == key)) begin
                    chosen = 1'b1;
                    pick = w;
                    r.outcome = OUT_STORE_FREE;
                end
            end
            for (int w = 0; w < WAYS; w++) begin
                if (!chosen && slot_pay[base+w].epoch < epoch) begin
                    chosen = 1'b1;
                    pick = w;
                    r.outcome = OUT_STORE_STALE;
                end
            end
            if (!chosen) begin
                best = slot_pay[base].depth;
                for (int w = 1; w < WAYS; w++) begin
                    if (slot_pay[base+w].depth < best) begin
                        best = slot_pay[base+w].depth;
                        pick = w;
                    end
                end
                r.outcome = OUT_STORE_SHALLOW;
            end
            r.way = pick[1:0];
            slot_valid[base+pick] = 1'b1;
            slot_key[base+pick] = key;
            slot_pay[base+pick] = '{kind: kind, epoch: epoch, depth: depth,
                                    score: score, move: move};
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : track
        probe_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
            end
            epoch = '0;
            awaited_results.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request awaiting it: outcome %0d", m_tuser);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("outcome", 16'(want.outcome), 16'(m_tuser));
                    check_field("way", 16'(want.way), 16'(m_tdata[1:0]));
                    check_field("found_score", want.score, m_tdata[17:2]);
                    check_field("found_node_kind", 16'(want.kind), 16'(m_tdata[19:18]));
                    check_field("found_depth", 16'(want.depth), 16'(m_tdata[27:20]));
                    check_field("found_move", want.move, m_tdata[43:28]);
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(probe_table(opcode_t'(s_tuser), s_tdata[63:0],
                    s_tdata[79:64], s_tdata[81:80], s_tdata[89:82], s_tdata[105:90]));
            end
            if (psel && penable && pwrite && pready && paddr == EPOCH_ADDR) begin
                epoch = pwdata[7:0];
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

// ===== bench/tb_four_way_transposition_table.sv =====
// ----------------------------------------------------------------------------
// tb_four_way_transposition_table
// Drives lookups and stores into the four-way transposition table: a directed
// run over empty, same-key, stale and shallowest replacement and epoch wrap,
// then random traffic on a few crowded buckets mixed with scattered keys,
// across several epochs. Both sides idle at random, and the result side holds
// off once long enough to back the table up. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_four_way_transposition_table;
    import fwtt_pkg::*;

    localparam logic [APB_AW-1:0] EPOCH_ADDR = '0;
    localparam int HOT_BUCKETS     = 8;
    localparam int KEYS_PER_BUCKET = 6;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int EPOCH_SPAN      = 250;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned awaited_count;
    int unsigned quiet_cycles;
    bit          steady;
    bit          hold_kick;

    logic [63:0] hot_keys [HOT_BUCKETS][KEYS_PER_BUCKET];
    logic [7:0]  epoch_plan [6] = '{8'd1, 8'd2, 8'd200, 8'd255, 8'd0, 8'd7};

    four_way_transposition_table dut (.*);

    fwtt_table_checker #(.EPOCH_ADDR(EPOCH_ADDR)) table_checker (.*);

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = ~aclk;
    end

    function automatic logic [63:0] bucket_key(input int bucket);
        logic [63:0] k;
        k = {$urandom, $urandom};
        k[BUCKET_BITS-1:0] = bucket[BUCKET_BITS-1:0];
        return k;
    endfunction

    task automatic send_request(
        input opcode_t            op,
        input logic [63:0]        key,
        input logic signed [15:0] score,
        input logic [1:0]         kind,
        input logic [7:0]         depth,
        input logic [15:0]        move
    );
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, move, depth, kind, score, key};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_count != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_epoch(input logic [7:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= EPOCH_ADDR;
        pwdata <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_kick) begin
                hold_kick = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= steady || $urandom_range(0, 99) >= 22;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [63:0] b0_keys [6];
        logic [63:0] top_keys [5];
        logic [63:0] key;
        logic [7:0]  depth;
        opcode_t     op;
        int          bucket;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOOKUP;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        hold_kick = 1'b0;

        for (int b = 0; b < HOT_BUCKETS; b++) begin
            bucket = (b == 0) ? 0 : (b == 1) ? BUCKETS - 1 : $urandom_range(0, BUCKETS - 1);
            for (int k = 0; k < KEYS_PER_BUCKET; k++) begin
                hot_keys[b][k] = bucket_key(bucket);
            end
        end
        b0_keys[0] = '0;
        for (int k = 1; k < 6; k++) begin
            b0_keys[k] = bucket_key(0);
        end
        top_keys[0] = '1;
        for (int k = 1; k < 5; k++) begin
            top_keys[k] = bucket_key(BUCKETS - 1);
        end

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        send_request(OP_LOOKUP, b0_keys[0], 16'sd0, 2'd0, 8'd0, 16'h0);
        send_request(OP_STORE, b0_keys[0], -16'sd32768, 2'd0, 8'd0, 16'h0000);
        send_request(OP_STORE, top_keys[0], 16'sd32767, 2'd3, 8'd255, 16'hFFFF);
        send_request(OP_LOOKUP, top_keys[0], 16'sd0, 2'd0, 8'd0, 16'h0);
        send_request(OP_STORE, b0_keys[0], 16'sh1234, 2'd1, 8'd5, 16'hA5A5);
        send_request(OP_STORE, b0_keys[1], -16'sd1, 2'd2, 8'd5, 16'h5A5A);
        send_request(OP_STORE, b0_keys[2], 16'sd77, 2'd3, 8'd5, 16'h0F0F);
        send_request(OP_STORE, b0_keys[3], -16'sd900, 2'd0, 8'd9, 16'hF0F0);
        send_request(OP_STORE, b0_keys[4], 16'sd3, 2'd1, 8'd1, 16'h1111);
        send_request(OP_LOOKUP, b0_keys[0], 16'sd0, 2'd0, 8'd0, 16'h0);
        send_request(OP_LOOKUP, b0_keys[4], 16'sd0, 2'd0, 8'd0, 16'h0);
        wait_until_drained();
        set_epoch(8'd1);
        send_request(OP_LOOKUP, b0_keys[2], 16'sd0, 2'd0, 8'd0, 16'h0);
        send_request(OP_STORE, b0_keys[5], 16'sd42, 2'd2, 8'd3, 16'h2222);
        send_request(OP_STORE, b0_keys[0], 16'sd43, 2'd3, 8'd4, 16'h3333);
        wait_until_drained();
        set_epoch(8'd255);
        for (int k = 1; k < 5; k++) begin
            send_request(OP_STORE, top_keys[k], 16'(k * 1000), 2'(k), 8'(10 - k), 16'(k));
        end
        wait_until_drained();
        set_epoch(8'd0);
        send_request(OP_STORE, top_keys[0], -16'sd5, 2'd1, 8'd2, 16'hBEEF);
        send_request(OP_LOOKUP, top_keys[0], 16'sd0, 2'd0, 8'd0, 16'h0);
        send_request(OP_LOOKUP, top_keys[1], 16'sd0, 2'd0, 8'd0, 16'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % EPOCH_SPAN == 0) begin
                wait_until_drained();
                set_epoch(epoch_plan[n / EPOCH_SPAN]);
            end
            if (n == 400) begin
                hold_kick = 1'b1;
            end
            steady = (n >= 900 && n < 1100);
            if ($urandom_range(0, 99) < 75) begin
                key = hot_keys[$urandom_range(0, HOT_BUCKETS - 1)]
                              [$urandom_range(0, KEYS_PER_BUCKET - 1)];
            end else begin
                key = {$urandom, $urandom};
            end
            op = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
            depth = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 7));
            send_request(op, key, 16'($urandom), 2'($urandom_range(0, 3)), depth,
                         16'($urandom));
        end

        wait_until_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && awaited_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== four_way_transposition_table.f =====
+incdir+rtl
rtl/fwtt_pkg.sv
rtl/four_way_transposition_table.sv
rtl/fwtt_checker.sv
bench/fwtt_table_checker.sv
bench/tb_four_way_transposition_table.sv
